@@ rtl/uvsg_pkg.sv @@
// Shared types, codes and constants of the UV sphere mesh generator.
`timescale 1ns / 1ps
package uvsg_pkg;

  localparam logic [2:0] REQ_BODY   = 3'd0;
  localparam logic [2:0] REQ_NPOLE  = 3'd1;
  localparam logic [2:0] REQ_SPOLE  = 3'd2;
  localparam logic [2:0] REQ_QUAD   = 3'd3;
  localparam logic [2:0] REQ_NCAP   = 3'd4;
  localparam logic [2:0] REQ_SCAP   = 3'd5;

  localparam logic [1:0] CFG_RADIUS   = 2'd0;
  localparam logic [1:0] CFG_SEGMENTS = 2'd1;
  localparam logic [1:0] CFG_RINGS    = 2'd2;

  localparam int TBL_DEPTH = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int PHASE_W   = 32;

  localparam logic signed [15:0] UNIT = 16'sd16384;

  // CORDIC start value (gain compensated) in Q3.30 and arctangent phases.
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [31:0] CORDIC_ATAN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    KIND_BODY,
    KIND_NPOLE,
    KIND_SPOLE,
    KIND_QUAD,
    KIND_TRI,
    KIND_ERR
  } req_kind_t;

  typedef struct packed {
    req_kind_t   kind;
    logic [11:0] a;
    logic [11:0] b;
    logic [11:0] c;
    logic [11:0] d;
  } meta_t;

  typedef enum logic [1:0] {
    TS_DIV,
    TS_SWEEP,
    TS_READY
  } tbl_state_t;

endpackage

@@ rtl/uvsg_req_if.sv @@
// Request channel interface of the UV sphere mesh generator.
`timescale 1ns / 1ps
interface uvsg_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [5:0] ring;
  logic [5:0] segment;

  modport source (output valid, output req_type, output ring, output segment, input ready);
  modport sink (input valid, input req_type, input ring, input segment, output ready);
endinterface

@@ rtl/uvsg_res_if.sv @@
// Result channel interface of the UV sphere mesh generator.
`timescale 1ns / 1ps
interface uvsg_res_if;
  logic               valid;
  logic               ready;
  logic               is_triangle;
  logic signed [17:0] pos_x;
  logic signed [17:0] pos_y;
  logic signed [17:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [11:0]        corner_a;
  logic [11:0]        corner_b;
  logic [11:0]        corner_c;
  logic               range_error;
  logic               last;

  modport source (output valid, output is_triangle, output pos_x, output pos_y, output pos_z,
                  output norm_x, output norm_y, output norm_z, output corner_a,
                  output corner_b, output corner_c, output range_error, output last,
                  input ready);
  modport sink (input valid, input is_triangle, input pos_x, input pos_y, input pos_z,
                input norm_x, input norm_y, input norm_z, input corner_a, input corner_b,
                input corner_c, input range_error, input last, output ready);
endinterface

@@ rtl/uvsg_phase_tbl.sv @@
// Angle phase tables, rebuilt by a serial divider and an accumulator sweep.
`timescale 1ns / 1ps
module uvsg_phase_tbl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic [6:0]                    seg_eff,
  input  logic [6:0]                    ring_eff,
  input  logic                          rd_en,
  input  logic [uvsg_pkg::IDX_W-1:0]    rd_ring,
  input  logic [uvsg_pkg::IDX_W-1:0]    rd_seg,
  output logic [uvsg_pkg::PHASE_W-1:0]  th_phase,
  output logic [uvsg_pkg::PHASE_W-1:0]  ph_phase,
  output logic                          ready
);

  localparam logic [uvsg_pkg::CNT_W-1:0] DIV_LAST   = 7'd33;
  localparam logic [uvsg_pkg::CNT_W-1:0] SWEEP_LAST = 7'd64;

  uvsg_pkg::tbl_state_t state_r, state_nxt;
  logic                        div_run, sweep_run;
  logic [uvsg_pkg::CNT_W-1:0]  cnt_r;
  logic [8:0]                  div_t, div_p;
  logic [8:0]                  rem_t_r, rem_p_r, rem_t_nxt, rem_p_nxt;
  logic                        qb_t, qb_p, nbit;
  logic [9:0]                  pre_t, pre_p;
  logic [31:0]                 quo_t_r, quo_p_r;
  logic [31:0]                 acc_t_r, acc_p_r;
  logic [8:0]                  fr_t_r, fr_p_r, fr_t_nxt, fr_p_nxt;
  logic [9:0]                  sum_t, sum_p;
  logic                        cy_t, cy_p;
  logic [31:0]                 th_mem [uvsg_pkg::TBL_DEPTH];
  logic [31:0]                 ph_mem [uvsg_pkg::TBL_DEPTH];

  // Theta divides 2^33 by 4(R-1), phi divides 2^33 by 2(S-1).
  assign div_t = {ring_eff - 7'd1, 2'b00};
  assign div_p = {1'b0, seg_eff - 7'd1, 1'b0};

  always_comb begin
    nbit      = (cnt_r == '0);
    pre_t     = {rem_t_r, nbit};
    pre_p     = {rem_p_r, nbit};
    qb_t      = (pre_t >= {1'b0, div_t});
    qb_p      = (pre_p >= {1'b0, div_p});
    rem_t_nxt = qb_t ? 9'(pre_t - {1'b0, div_t}) : pre_t[8:0];
    rem_p_nxt = qb_p ? 9'(pre_p - {1'b0, div_p}) : pre_p[8:0];
    sum_t     = {1'b0, fr_t_r} + {1'b0, rem_t_r};
    sum_p     = {1'b0, fr_p_r} + {1'b0, rem_p_r};
    cy_t      = (sum_t >= {1'b0, div_t});
    cy_p      = (sum_p >= {1'b0, div_p});
    fr_t_nxt  = cy_t ? 9'(sum_t - {1'b0, div_t}) : sum_t[8:0];
    fr_p_nxt  = cy_p ? 9'(sum_p - {1'b0, div_p}) : sum_p[8:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      uvsg_pkg::TS_DIV:   if (cnt_r == DIV_LAST) state_nxt = uvsg_pkg::TS_SWEEP;
      uvsg_pkg::TS_SWEEP: if (cnt_r == SWEEP_LAST) state_nxt = uvsg_pkg::TS_READY;
      default:            state_nxt = uvsg_pkg::TS_READY;
    endcase
    if (restart) state_nxt = uvsg_pkg::TS_DIV;
  end

  always_comb begin
    div_run   = 1'b0;
    sweep_run = 1'b0;
    ready     = 1'b0;
    case (state_r)
      uvsg_pkg::TS_DIV:   div_run = 1'b1;
      uvsg_pkg::TS_SWEEP: sweep_run = 1'b1;
      default:            ready = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uvsg_pkg::TS_DIV;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      cnt_r   <= '0;
      rem_t_r <= '0;
      rem_p_r <= '0;
    end else if (div_run) begin
      rem_t_r <= rem_t_nxt;
      rem_p_r <= rem_p_nxt;
      quo_t_r <= {quo_t_r[30:0], qb_t};
      quo_p_r <= {quo_p_r[30:0], qb_p};
      if (cnt_r == DIV_LAST) begin
        cnt_r   <= '0;
        acc_t_r <= '0;
        acc_p_r <= '0;
        fr_t_r  <= div_t >> 1;
        fr_p_r  <= div_p >> 1;
      end else begin
        cnt_r <= cnt_r + 7'd1;
      end
    end else if (sweep_run) begin
      cnt_r   <= cnt_r + 7'd1;
      fr_t_r  <= fr_t_nxt;
      fr_p_r  <= fr_p_nxt;
      acc_t_r <= acc_t_r + quo_t_r + 32'(cy_t);
      acc_p_r <= acc_p_r + quo_p_r + 32'(cy_p);
    end
  end

  // Entry k of phi holds step k; entry r of theta holds step r+1.
  always_ff @(posedge clk) begin
    if (sweep_run && (cnt_r != SWEEP_LAST)) ph_mem[cnt_r[5:0]] <= acc_p_r;
    if (sweep_run && (cnt_r != '0)) th_mem[6'(cnt_r - 7'd1)] <= acc_t_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      th_phase <= th_mem[rd_ring];
      ph_phase <= ph_mem[rd_seg];
    end
  end

endmodule

@@ rtl/uvsg_cordic.sv @@
// Pipelined rotation CORDIC giving sine and cosine of a 32 bit phase in Q1.14.
`timescale 1ns / 1ps
module uvsg_cordic #(
  parameter int STAGES = 16
) (
  input  logic                     clk,
  input  logic [STAGES+1:0]        en,
  input  logic [31:0]              phase_i,
  output logic signed [15:0]       sin_o,
  output logic signed [15:0]       cos_o
);

  logic signed [33:0] x_r [STAGES+1];
  logic signed [33:0] y_r [STAGES+1];
  logic signed [32:0] z_r [STAGES+1];
  logic [1:0]         q_r [STAGES+1];
  logic [31:0]        pq, zz;
  logic signed [15:0] c_un, s_un;

  function automatic logic signed [15:0] sat_unit(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd32768) >>> 16;
    if (t > 34'sd16384) return uvsg_pkg::UNIT;
    if (t < -34'sd16384) return -uvsg_pkg::UNIT;
    return t[15:0];
  endfunction

  assign pq = phase_i + 32'h2000_0000;
  assign zz = phase_i - {pq[31:30], 30'b0};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0] <= uvsg_pkg::CORDIC_X0;
      y_r[0] <= '0;
      z_r[0] <= {zz[31], zz};
      q_r[0] <= pq[31:30];
    end
  end

  for (genvar j = 1; j <= STAGES; j++) begin : g_iter
    localparam int I = j - 1;
    localparam logic signed [32:0] ANG = {1'b0, uvsg_pkg::CORDIC_ATAN[I]};
    always_ff @(posedge clk) begin
      if (en[j]) begin
        q_r[j] <= q_r[j-1];
        if (!z_r[j-1][32]) begin
          x_r[j] <= x_r[j-1] - (y_r[j-1] >>> I);
          y_r[j] <= y_r[j-1] + (x_r[j-1] >>> I);
          z_r[j] <= z_r[j-1] - ANG;
        end else begin
          x_r[j] <= x_r[j-1] + (y_r[j-1] >>> I);
          y_r[j] <= y_r[j-1] - (x_r[j-1] >>> I);
          z_r[j] <= z_r[j-1] + ANG;
        end
      end
    end
  end

  assign c_un = sat_unit(x_r[STAGES]);
  assign s_un = sat_unit(y_r[STAGES]);

  // Fold the quadrant back in.
  always_ff @(posedge clk) begin
    if (en[STAGES+1]) begin
      case (q_r[STAGES])
        2'd0: begin cos_o <= c_un;  sin_o <= s_un;  end
        2'd1: begin cos_o <= -s_un; sin_o <= c_un;  end
        2'd2: begin cos_o <= -c_un; sin_o <= -s_un; end
        default: begin cos_o <= s_un; sin_o <= -c_un; end
      endcase
    end
  end

endmodule

@@ rtl/uv_sphere_mesh_generator.sv @@
// Top level of the UV sphere mesh generator: decode, CORDIC pipeline and output stage.
`timescale 1ns / 1ps
// Each request item on in_ch asks for one piece of a latitude-longitude sphere: a body
// vertex, a pole vertex, the two triangles of a body quad or one cap triangle. Result
// items leave on out_ch; a quad request gives two result items, every other request one,
// and the last result item of a request carries last = 1.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes radius, segment count and
// ring count; the user must see that it is written only while no request is in flight.
// From acceptance to the first result item a request passes one decode and table read
// stage, CORDIC_STAGES + 2 CORDIC stages, two multiply stages, one normal select stage
// and the output register. One request item can be accepted in every cycle while the
// tables are ready and no stage stalls; a quad keeps the output register for two items.
// After reset and after every configuration write the theta and phi phase tables are
// rebuilt: a serial division followed by an accumulator sweep,
// during which in_ch.ready is low. Reset clears the configuration to radius 1.0,
// 32 segments and 16 rings and drops every item in flight.
// When the receiver stalls, the result item waits in the output register while earlier
// stages keep filling any free slots; each stage moves only when the one after it is
// empty or moving, so nothing is lost or repeated.
module uv_sphere_mesh_generator #(
  parameter int MAX_SEGMENTS  = 64,
  parameter int MAX_RINGS     = 64,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  uvsg_req_if.sink    in_ch,
  uvsg_res_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int S_CEND = CORDIC_STAGES + 2;
  localparam int S_PROD = CORDIC_STAGES + 3;
  localparam int S_NORM = CORDIC_STAGES + 4;
  localparam int S_MUL  = CORDIC_STAGES + 5;
  localparam int S_OUT  = CORDIC_STAGES + 6;
  localparam int NST    = CORDIC_STAGES + 7;

  logic [15:0] radius_r;
  logic [6:0]  seg_cnt_r, ring_cnt_r;
  logic [6:0]  seg_eff, ring_eff;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= 16'd256;
      seg_cnt_r  <= 7'd32;
      ring_cnt_r <= 7'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        uvsg_pkg::CFG_RADIUS:   radius_r   <= cfg_wdata;
        uvsg_pkg::CFG_SEGMENTS: seg_cnt_r  <= cfg_wdata[6:0];
        uvsg_pkg::CFG_RINGS:    ring_cnt_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // The counts are used saturated to the supported mesh size.
  always_comb begin
    if (seg_cnt_r < 7'd3) seg_eff = 7'd3;
    else if ({2'b00, seg_cnt_r} > 9'(MAX_SEGMENTS)) seg_eff = 7'(MAX_SEGMENTS);
    else seg_eff = seg_cnt_r;
    if (ring_cnt_r < 7'd4) ring_eff = 7'd4;
    else if ({2'b00, ring_cnt_r} > 9'(MAX_RINGS)) ring_eff = 7'(MAX_RINGS);
    else ring_eff = ring_cnt_r;
  end

  logic [NST-1:0]   v_r;
  logic [NST-1:0]   en;
  logic             tbl_ready, in_fire, out_take, sec_r;
  uvsg_pkg::meta_t  meta_r [NST];
  uvsg_pkg::meta_t  dec;

  assign in_ch.ready = tbl_ready && en[0];
  assign in_fire     = in_ch.valid && in_ch.ready;

  // A stage loads when it is empty or its content moves on.
  for (genvar i = 0; i < NST - 1; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end
  assign en[NST-1] = !v_r[NST-1] || out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_fire;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Request decode: range checks and the vertex numbers of triangle corners.
  logic [7:0]  r8, s8, rr8, ss8;
  logic [12:0] rs;
  logic [13:0] top_w, base_w;
  logic [11:0] i0, i1, i2, i3, top_i, base_i;
  logic        body_ok, quad_ok, cap_ok;

  always_comb begin
    r8      = {2'b00, in_ch.ring};
    s8      = {2'b00, in_ch.segment};
    rr8     = {1'b0, ring_eff};
    ss8     = {1'b0, seg_eff};
    body_ok = (r8 + 8'd3 <= rr8) && (s8 + 8'd1 <= ss8);
    quad_ok = (r8 + 8'd4 <= rr8) && (s8 + 8'd2 <= ss8);
    cap_ok  = (s8 + 8'd2 <= ss8);
    rs      = in_ch.ring * seg_eff;
    i0      = 12'(rs + {7'd0, in_ch.segment});
    i2      = i0 + 12'd1;
    i3      = 12'(i0 + {5'd0, seg_eff});
    i1      = i3 + 12'd1;
    top_w   = (ring_eff - 7'd2) * seg_eff;
    base_w  = (ring_eff - 7'd3) * seg_eff;
    top_i   = top_w[11:0];
    base_i  = base_w[11:0];
    dec     = '{kind: uvsg_pkg::KIND_ERR, a: '0, b: '0, c: '0, d: '0};
    case (in_ch.req_type)
      uvsg_pkg::REQ_BODY:  if (body_ok) dec.kind = uvsg_pkg::KIND_BODY;
      uvsg_pkg::REQ_NPOLE: dec.kind = uvsg_pkg::KIND_NPOLE;
      uvsg_pkg::REQ_SPOLE: dec.kind = uvsg_pkg::KIND_SPOLE;
      uvsg_pkg::REQ_QUAD: begin
        if (quad_ok) dec = '{kind: uvsg_pkg::KIND_QUAD, a: i0, b: i1, c: i2, d: i3};
      end
      uvsg_pkg::REQ_NCAP: begin
        if (cap_ok) begin
          dec = '{kind: uvsg_pkg::KIND_TRI, a: top_i, b: {6'd0, in_ch.segment},
                  c: 12'({6'd0, in_ch.segment} + 12'd1), d: '0};
        end
      end
      uvsg_pkg::REQ_SCAP: begin
        if (cap_ok) begin
          dec = '{kind: uvsg_pkg::KIND_TRI, a: top_i + 12'd1,
                  b: base_i + {6'd0, in_ch.segment} + 12'd1,
                  c: base_i + {6'd0, in_ch.segment}, d: '0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) meta_r[0] <= dec;
  end

  for (genvar i = 1; i < NST; i++) begin : g_meta
    always_ff @(posedge clk) begin
      if (en[i]) meta_r[i] <= meta_r[i-1];
    end
  end

  // Phase tables and the two CORDIC pipelines.
  logic [31:0]        th_phase, ph_phase;
  logic signed [15:0] st, ct, sp, cp;

  uvsg_phase_tbl u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (cfg_we),
    .seg_eff  (seg_eff),
    .ring_eff (ring_eff),
    .rd_en    (en[0]),
    .rd_ring  (in_ch.ring),
    .rd_seg   (in_ch.segment),
    .th_phase (th_phase),
    .ph_phase (ph_phase),
    .ready    (tbl_ready)
  );

  uvsg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_th (
    .clk     (clk),
    .en      (en[S_CEND:1]),
    .phase_i (th_phase),
    .sin_o   (st),
    .cos_o   (ct)
  );

  uvsg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ph (
    .clk     (clk),
    .en      (en[S_CEND:1]),
    .phase_i (ph_phase),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  function automatic logic signed [15:0] rnd_sat14(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = (v + 32'sd8192) >>> 14;
    if (t > 32'sd16384) return uvsg_pkg::UNIT;
    if (t < -32'sd16384) return -uvsg_pkg::UNIT;
    return t[15:0];
  endfunction

  logic signed [31:0] px_r, pz_r;
  logic signed [15:0] ct_r;
  logic signed [15:0] n_r [3];
  logic signed [15:0] nm_r [3];
  logic signed [32:0] m_r [3];
  logic signed [15:0] no_r [3];
  logic signed [17:0] pos_r [3];
  logic signed [32:0] pr [3];

  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      px_r <= st * cp;
      pz_r <= st * sp;
      ct_r <= ct;
    end
  end

  // Normal select: the body vector, a pole vector, or zero for triangles and errors.
  always_ff @(posedge clk) begin
    if (en[S_NORM]) begin
      case (meta_r[S_PROD].kind)
        uvsg_pkg::KIND_BODY: begin
          n_r[0] <= rnd_sat14(px_r);
          n_r[1] <= ct_r;
          n_r[2] <= -rnd_sat14(pz_r);
        end
        uvsg_pkg::KIND_NPOLE: begin
          n_r[0] <= '0; n_r[1] <= uvsg_pkg::UNIT; n_r[2] <= '0;
        end
        uvsg_pkg::KIND_SPOLE: begin
          n_r[0] <= '0; n_r[1] <= -uvsg_pkg::UNIT; n_r[2] <= '0;
        end
        default: begin
          n_r[0] <= '0; n_r[1] <= '0; n_r[2] <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      for (int k = 0; k < 3; k++) begin
        m_r[k]  <= $signed({1'b0, radius_r}) * n_r[k];
        nm_r[k] <= n_r[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) pr[k] = (m_r[k] + 33'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      for (int k = 0; k < 3; k++) begin
        pos_r[k] <= pr[k][17:0];
        no_r[k]  <= nm_r[k];
      end
    end
  end

  // Output stage; a quad item is shown twice, the second time with its other triangle.
  uvsg_pkg::meta_t om;
  logic            om_quad;

  assign om       = meta_r[S_OUT];
  assign om_quad  = (om.kind == uvsg_pkg::KIND_QUAD);
  assign out_take = v_r[S_OUT] && out_ch.ready && (!om_quad || sec_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= 1'b0;
    end else if (out_take) begin
      sec_r <= 1'b0;
    end else if (v_r[S_OUT] && out_ch.ready && om_quad) begin
      sec_r <= 1'b1;
    end
  end

  assign out_ch.valid       = v_r[S_OUT];
  assign out_ch.is_triangle = om_quad || (om.kind == uvsg_pkg::KIND_TRI);
  assign out_ch.pos_x       = pos_r[0];
  assign out_ch.pos_y       = pos_r[1];
  assign out_ch.pos_z       = pos_r[2];
  assign out_ch.norm_x      = no_r[0];
  assign out_ch.norm_y      = no_r[1];
  assign out_ch.norm_z      = no_r[2];
  assign out_ch.corner_a    = om.a;
  assign out_ch.corner_b    = sec_r ? om.d : om.b;
  assign out_ch.corner_c    = sec_r ? om.b : om.c;
  assign out_ch.range_error = (om.kind == uvsg_pkg::KIND_ERR);
  assign out_ch.last        = !(om_quad && !sec_r);

  // The second half of a quad is only ever held for a valid quad item.
  a_sec_quad: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r |-> (v_r[S_OUT] && om_quad))
    else $error("second triangle flag set without a quad in the output register");

  // Handing over the first triangle of a quad always brings up the second one next.
  a_quad_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && om_quad && !sec_r) |=>
      (out_ch.valid && sec_r && out_ch.last))
    else $error("quad did not present its second triangle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.range_error) |->
      (!out_ch.is_triangle && out_ch.pos_y == 18'sd0 && out_ch.norm_y == 16'sd0 &&
       out_ch.corner_a == 12'd0))
    else $error("range error item carries data");

  a_tri_nonorm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_triangle) |->
      (out_ch.norm_x == 16'sd0 && out_ch.norm_y == 16'sd0 && out_ch.norm_z == 16'sd0))
    else $error("triangle item carries a normal");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_we) |-> !in_ch.ready)
    else $error("request accepted while phase tables are rebuilt");

endmodule
